>>> rtl/plc_pkg.sv
// Shared types, widths and color node tables for the piecewise linear colormap core.
// No dependencies; every other file of the core imports this package.
package plc_pkg;

	localparam int IDX_W      = 16;
	localparam int CH_W       = 8;
	localparam int NUM_CH     = 3;
	localparam int NODE_COUNT = 8;
	localparam int BIN_W      = 3;
	localparam int P_W        = IDX_W + BIN_W;
	localparam int PROD_W     = IDX_W + CH_W;
	localparam int NUM_W      = IDX_W + CH_W + 2;
	localparam int DEN_W      = IDX_W + 1;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;

	localparam logic [FIFO_AW:0] FIFO_FULL = (FIFO_AW + 1)'(FIFO_DEPTH);
	localparam logic [IDX_W-1:0] NUM_COLORS_RST = IDX_W'(256);

	localparam int CH_RED   = 0;
	localparam int CH_GREEN = 1;
	localparam int CH_BLUE  = 2;

	localparam logic [CH_W-1:0] RAMP [0:NUM_CH-1][0:NODE_COUNT-1] = '{
		'{8'd0,   8'd105, 8'd0,   8'd180, 8'd255, 8'd255, 8'd255, 8'd255},
		'{8'd0,   8'd145, 8'd255, 8'd255, 8'd215, 8'd143, 8'd69,  8'd0},
		'{8'd255, 8'd2,   8'd29,  8'd0,   8'd6,   8'd1,   8'd0,   8'd0}
	};

	typedef struct packed {
		logic             err;
		logic [BIN_W-1:0] bin;
		logic [IDX_W-1:0] rem;
	} plc_job_t;

endpackage

>>> rtl/piecewise_linear_colormap_core.sv
// The core maps a palette index to an RGB triple on an eight-node color ramp for a palette of
// num_colors entries and takes one item per clock while s_tready is high; an item passes through
// the three bin division stages, the queue, and the lookup, multiply, sum and eight
// quotient-bit stages of the blend divider before its result appears.
// A four-entry queue lets the front keep accepting while the output is held, and an index not
// below num_colors returns black with index_error set. Configuration writes are always taken.
// Depends on plc_pkg, plc_front, plc_fifo, plc_div and plc_back.
module piecewise_linear_colormap_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [plc_pkg::IDX_W-1:0]  cfg_data,  // num_colors
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [plc_pkg::IDX_W-1:0]  s_tdata,   // [15:0] color_index
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [3*plc_pkg::CH_W-1:0] m_tdata,   // [7:0] red, [15:8] green, [23:16] blue
	output logic                       m_tuser    // [0] index_error
);
	import plc_pkg::*;

	logic [IDX_W-1:0] num_colors_q;
	plc_job_t         fr_job, bk_job;
	logic             fr_valid, fr_ready, bk_valid, bk_ready;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_colors_q <= NUM_COLORS_RST;
		end else if (cfg_valid && cfg_ready) begin
			num_colors_q <= cfg_data;
		end
	end

	plc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.n         (num_colors_q),
		.job_valid (fr_valid),
		.job_ready (fr_ready),
		.job       (fr_job)
	);

	plc_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (fr_valid),
		.wr_ready (fr_ready),
		.wr_data  (fr_job),
		.rd_valid (bk_valid),
		.rd_ready (bk_ready),
		.rd_data  (bk_job)
	);

	plc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (bk_valid),
		.job_ready (bk_ready),
		.job       (bk_job),
		.n         (num_colors_q),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

>>> rtl/plc_front.sv
// Front end: accepts color indexes, flags out-of-range ones and splits index*7 into bin and
// remainder by a three-stage restoring division. Depends on plc_pkg.
module plc_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [plc_pkg::IDX_W-1:0] s_tdata,   // [15:0] color_index
	input  logic [plc_pkg::IDX_W-1:0] n,
	output logic                      job_valid,
	input  logic                      job_ready,
	output plc_pkg::plc_job_t         job
);
	import plc_pkg::*;

	logic           en;
	logic           vld_s1, vld_s2, vld_s3;
	logic           err_s1, err_s2, err_s3;
	logic [P_W-1:0] p_s1, r_s2, r_s3;
	logic           b2_s2, b2_s3, b1_s3;
	logic [P_W-1:0] n4, n2, n1, p_in;
	logic           b0;

	assign n4   = {1'b0, n, 2'b00};
	assign n2   = {2'b00, n, 1'b0};
	assign n1   = {3'b000, n};
	assign p_in = {s_tdata, 3'b000} - {3'b000, s_tdata};

	assign en        = !vld_s3 || job_ready;
	assign s_tready  = en;
	assign job_valid = vld_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1   <= p_in;
			err_s1 <= (s_tdata >= n);
			err_s2 <= err_s1;
			b2_s2  <= (p_s1 >= n4);
			r_s2   <= (p_s1 >= n4) ? p_s1 - n4 : p_s1;
			err_s3 <= err_s2;
			b2_s3  <= b2_s2;
			b1_s3  <= (r_s2 >= n2);
			r_s3   <= (r_s2 >= n2) ? r_s2 - n2 : r_s2;
		end
	end

	assign b0      = (r_s3 >= n1);
	assign job.err = err_s3;
	assign job.bin = {b2_s3, b1_s3, b0};
	assign job.rem = b0 ? IDX_W'(r_s3 - n1) : IDX_W'(r_s3);

endmodule

>>> rtl/plc_fifo.sv
// Short register queue that decouples the front end from the blend pipeline.
// Depends on plc_pkg for the entry type and depth.
module plc_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_valid,
	output logic              wr_ready,
	input  plc_pkg::plc_job_t wr_data,
	output logic              rd_valid,
	input  logic              rd_ready,
	output plc_pkg::plc_job_t rd_data
);
	import plc_pkg::*;

	plc_job_t           mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wptr_q, rptr_q;
	logic [FIFO_AW:0]   cnt_q;
	logic               push, pop;

	assign wr_ready = (cnt_q != FIFO_FULL);
	assign rd_valid = (cnt_q != '0);
	assign rd_data  = mem_q[rptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

endmodule

>>> rtl/plc_div.sv
// One color lane of the blend divider: an eight-stage restoring division that yields one
// quotient bit per stage. Depends on plc_pkg.
module plc_div (
	input  logic                      clk,
	input  logic                      en,
	input  logic [plc_pkg::NUM_W-1:0] num,
	input  logic [plc_pkg::DEN_W-1:0] den,
	output logic [plc_pkg::CH_W-1:0]  quo
);
	import plc_pkg::*;

	logic [NUM_W-1:0] rin   [CH_W];
	logic [NUM_W-1:0] rdiff [CH_W];
	logic [CH_W-1:0]  qin   [CH_W];
	logic [CH_W-1:0]  qbit;
	logic [NUM_W-1:0] rem_s [1:CH_W-1];
	logic [CH_W-1:0]  quo_s [1:CH_W];

	for (genvar k = 0; k < CH_W; k++) begin : g_step
		if (k == 0) begin : g_first
			assign rin[k] = num;
			assign qin[k] = '0;
		end else begin : g_next
			assign rin[k] = rem_s[k];
			assign qin[k] = quo_s[k];
		end
		assign rdiff[k] = rin[k] - (NUM_W'(den) << (CH_W - 1 - k));
		assign qbit[k]  = (rin[k] >= (NUM_W'(den) << (CH_W - 1 - k)));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 1; k < CH_W; k++) begin
				rem_s[k] <= qbit[k-1] ? rdiff[k-1] : rin[k-1];
			end
			for (int k = 1; k <= CH_W; k++) begin
				quo_s[k] <= {qin[k-1][CH_W-2:0], qbit[k-1]};
			end
		end
	end

	assign quo = quo_s[CH_W];

endmodule

>>> rtl/plc_back.sv
// Back end: looks up the two color nodes of each bin, forms the weighted sums and divides
// them by the palette size in three lanes. Depends on plc_pkg and plc_div.
module plc_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       job_valid,
	output logic                       job_ready,
	input  plc_pkg::plc_job_t          job,
	input  logic [plc_pkg::IDX_W-1:0]  n,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [3*plc_pkg::CH_W-1:0] m_tdata,  // [7:0] red, [15:8] green, [23:16] blue
	output logic                       m_tuser   // [0] index_error
);
	import plc_pkg::*;

	localparam int LAT = 3 + CH_W;

	logic              en;
	logic              vld_s [1:LAT];
	logic              err_s [1:LAT];
	logic [IDX_W-1:0]  rem_s1, nrem_s1;
	logic [CH_W-1:0]   lo_s1 [NUM_CH];
	logic [CH_W-1:0]   hi_s1 [NUM_CH];
	logic [PROD_W-1:0] pa_s2 [NUM_CH];
	logic [PROD_W-1:0] pb_s2 [NUM_CH];
	logic [NUM_W-1:0]  num_s3 [NUM_CH];
	logic [CH_W-1:0]   quo [NUM_CH];
	logic [BIN_W-1:0]  bin_hi;
	logic [DEN_W-1:0]  den;

	assign en        = !vld_s[LAT] || m_tready;
	assign job_ready = en;
	assign bin_hi    = BIN_W'(job.bin + 1'b1);
	assign den       = {n, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= LAT; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (en) begin
			vld_s[1] <= job_valid;
			for (int k = 2; k <= LAT; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			err_s[1] <= job.err;
			for (int k = 2; k <= LAT; k++) begin
				err_s[k] <= err_s[k-1];
			end
			rem_s1  <= job.rem;
			nrem_s1 <= n - job.rem;
			for (int c = 0; c < NUM_CH; c++) begin
				lo_s1[c]  <= RAMP[c][job.bin];
				hi_s1[c]  <= RAMP[c][bin_hi];
				pa_s2[c]  <= PROD_W'(lo_s1[c]) * PROD_W'(nrem_s1);
				pb_s2[c]  <= PROD_W'(hi_s1[c]) * PROD_W'(rem_s1);
				num_s3[c] <= ((NUM_W'(pa_s2[c]) + NUM_W'(pb_s2[c])) << 1) + NUM_W'(n);
			end
		end
	end

	for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
		plc_div u_div (
			.clk (clk),
			.en  (en),
			.num (num_s3[c]),
			.den (den),
			.quo (quo[c])
		);
	end

	assign m_tvalid = vld_s[LAT];
	assign m_tuser  = err_s[LAT];
	assign m_tdata  = err_s[LAT] ? '0 : {quo[CH_BLUE], quo[CH_GREEN], quo[CH_RED]};

endmodule
